@@ hw/rtl/lphi_pkg.sv @@
// ----------------------------------------------------------------------------
// lphi_pkg
// Shared types and constants for the linear probing hash insert core.
// ----------------------------------------------------------------------------
package lphi_pkg;

  localparam int ID_W      = 31;  // employee id width
  localparam int TAG_W     = 32;  // name tag width
  localparam int OUT_IDX_W = 4;   // width of reported slot indexes
  localparam int DIGIT_W   = 4;   // id bits folded into the remainder per cycle
  localparam int ID_DIGITS = 8;   // digits in the id padded to 32 bits
  localparam int ID_PAD_W  = DIGIT_W * ID_DIGITS;
  localparam int DCNT_W    = $clog2(ID_DIGITS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SEEK,
    ST_PROBE
  } lphi_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic load;
    logic mod_step;
    logic probe_init;
    logic probe_step;
    logic finish;
  } lphi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic q_vld;
    logic q_free;
    logic probe_last;
  } lphi_stat_t;

  typedef enum logic {
    RES_STORED = 1'b0,
    RES_FULL   = 1'b1
  } lphi_res_t;

endpackage

@@ hw/rtl/lphi_ctrl.sv @@
// ----------------------------------------------------------------------------
// lphi_ctrl
// Sequencer: clearing pass, id reduction, then slot-by-slot probing.
// ----------------------------------------------------------------------------
module lphi_ctrl
  import lphi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  lphi_stat_t stat,
  output lphi_cmd_t  cmd,
  output logic       busy
);

  lphi_state_t state;
  lphi_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_next = ST_SEEK;
        end
      end
      ST_SEEK: begin
        cmd.probe_init = 1'b1;
        state_next     = ST_PROBE;
      end
      ST_PROBE: begin
        cmd.probe_step = 1'b1;
        // stop on the first free slot, or once every slot has been seen
        if (stat.q_vld && (stat.q_free || stat.probe_last)) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ hw/rtl/lphi_dp.sv @@
// ----------------------------------------------------------------------------
// lphi_dp
// Datapath: id remainder unit, used-mark memory, record store, result regs.
// ----------------------------------------------------------------------------
module lphi_dp
  import lphi_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lphi_cmd_t            cmd,
  output lphi_stat_t           stat,
  input  logic [ID_W-1:0]      emp_id,
  input  logic [TAG_W-1:0]     name_tag,
  output logic                 done,
  output logic                 status,
  output logic [OUT_IDX_W-1:0] slot,
  output logic [OUT_IDX_W-1:0] home_slot
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int REC_W = ID_W + TAG_W + IDX_W;
  localparam logic [IDX_W:0]   SLOTS_X = (IDX_W + 1)'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // storage
  logic             used_mem [SLOTS];
  logic [REC_W-1:0] rec_mem  [SLOTS];

  // registers
  logic [ID_PAD_W-1:0] id_sh;
  logic [TAG_W-1:0]    tag;
  logic [ID_W-1:0]     id_hold;
  logic [IDX_W-1:0]    rem;
  logic [DCNT_W-1:0]   dcnt;
  logic [IDX_W-1:0]    clr_ptr;
  logic [IDX_W-1:0]    rd_ptr;
  logic [IDX_W-1:0]    chk_ptr;
  logic [IDX_W-1:0]    pcnt;
  logic                q_vld;
  logic                used_q;

  logic [IDX_W-1:0]    rem_next;
  logic [IDX_W:0]      acc;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  logic                mem_wd;
  logic [IDX_W+OUT_IDX_W-1:0] chk_ext;
  logic [IDX_W+OUT_IDX_W-1:0] rem_ext;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == LAST_IDX) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // one digit of the id into the remainder: shift in a bit, reduce once
  always_comb begin
    acc = {1'b0, rem};
    for (int b = 0; b < DIGIT_W; b++) begin
      acc = {acc[IDX_W-1:0], id_sh[ID_PAD_W-1-b]};
      if (acc >= SLOTS_X) begin
        acc = acc - SLOTS_X;
      end
    end
    rem_next = acc[IDX_W-1:0];
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = chk_ptr;
    mem_wd = 1'b1;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
      mem_wa = clr_ptr;
      mem_wd = 1'b0;
    end else if (cmd.finish && !used_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[mem_wa] <= mem_wd;
    end
    used_q <= used_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && !used_q) begin
      rec_mem[chk_ptr] <= {id_hold, tag, rem};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
      dcnt    <= '0;
      q_vld   <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.clr_step) begin
        clr_ptr <= clr_ptr + 1'b1;
      end
      if (cmd.load) begin
        dcnt <= '0;
      end else if (cmd.mod_step) begin
        dcnt <= dcnt + 1'b1;
      end
      if (cmd.probe_init) begin
        q_vld <= 1'b0;
      end else if (cmd.probe_step) begin
        q_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_sh   <= {{(ID_PAD_W - ID_W){1'b0}}, emp_id};
      id_hold <= emp_id;
      tag     <= name_tag;
      rem     <= '0;
    end else if (cmd.mod_step) begin
      id_sh <= id_sh << DIGIT_W;
      rem   <= rem_next;
    end
    if (cmd.probe_init) begin
      rd_ptr  <= rem;
      chk_ptr <= rem;
      pcnt    <= '0;
    end else if (cmd.probe_step) begin
      rd_ptr <= wrap_inc(rd_ptr);
      if (q_vld && used_q) begin
        chk_ptr <= wrap_inc(chk_ptr);
        pcnt    <= pcnt + 1'b1;
      end
    end
    if (cmd.finish) begin
      home_slot <= rem_ext[OUT_IDX_W-1:0];
      if (used_q) begin
        status <= RES_FULL;
        slot   <= '0;
      end else begin
        status <= RES_STORED;
        slot   <= chk_ext[OUT_IDX_W-1:0];
      end
    end
  end

  assign chk_ext = {{OUT_IDX_W{1'b0}}, chk_ptr};
  assign rem_ext = {{OUT_IDX_W{1'b0}}, rem};

  assign stat.clr_last   = (clr_ptr == LAST_IDX);
  assign stat.mod_last   = (dcnt == DCNT_W'(ID_DIGITS - 1));
  assign stat.q_vld      = q_vld;
  assign stat.q_free     = !used_q;
  assign stat.probe_last = (pcnt == LAST_IDX);

endmodule

@@ hw/rtl/linear_probe_hash_insert_core.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_insert_core
// Hash table insert with linear probing over SLOTS slots.
// ----------------------------------------------------------------------------
// Each item is an insert request (emp_id, name_tag). The home slot is emp_id
// mod SLOTS; from there the table is probed slot by slot, wrapping, to the
// first free slot, where id, tag and home slot are stored and the slot is
// marked used. If every slot is taken nothing is written and status reports
// full with slot 0. After reset the core runs a clearing pass over the
// used-mark memory, one slot a cycle, holding busy high throughout.
// An item is taken when start is high and busy low. The remainder unit folds
// four id bits a cycle, the seek state loads the probe pointers, then the
// used-mark memory is read one slot a cycle through a registered read port
// until a free slot is found or every slot has been seen. Busy stays high
// meanwhile, so a new item is taken only after the last one's result. The
// result appears for one cycle with done high, and busy is already low in
// that cycle so the next item may be started there. Results cannot be
// stalled.
// ----------------------------------------------------------------------------
module linear_probe_hash_insert_core
  import lphi_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [ID_W-1:0]      emp_id,
  input  logic [TAG_W-1:0]     name_tag,
  output logic                 done,
  output logic                 status,
  output logic [OUT_IDX_W-1:0] slot,
  output logic [OUT_IDX_W-1:0] home_slot
);

  // command and status between sequencer and datapath
  lphi_cmd_t  cmd;
  lphi_stat_t stat;

  // sequencer: clear, reduce the id, then probe until free slot or full
  lphi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: remainder unit, used marks, record store and result item
  lphi_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .emp_id    (emp_id),
    .name_tag  (name_tag),
    .done      (done),
    .status    (status),
    .slot      (slot),
    .home_slot (home_slot)
  );

endmodule

@@ hw/rtl/lphi_checker.sv @@
// ----------------------------------------------------------------------------
// lphi_checker
// Port-level checks on the linear probing hash insert core.
// ----------------------------------------------------------------------------
module lphi_checker
  import lphi_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic                 status,
  input logic [OUT_IDX_W-1:0] slot
);

  // an accepted item keeps the core busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a result only appears once the core has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // one result per item: strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // a full table reports slot zero
  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    (done && status == RES_FULL) |-> (slot == '0))
    else $error("full result with non-zero slot");

endmodule

bind linear_probe_hash_insert_core lphi_checker u_lphi_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .status (status),
  .slot   (slot)
);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for linear_probe_hash_insert_core: a directed table
// fills the 16-slot table through collisions, wrap-around and a duplicate id,
// then drives inserts into the full table; a random part follows. Results
// are checked against a given row value, else a local probe-sequence model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lphi_pkg::*;

  localparam int SLOTS      = 16;
  localparam int RAND_ITEMS = 1900;
  localparam int CALM_TAIL  = 200;   // last random items, sent with no idling
  localparam int STALL_MAX  = 1000;  // cycles without any item or result moving
  localparam int NUM_DIR    = 20;

  // One insert outcome as it appears on the result ports.
  typedef struct packed {
    lphi_res_t             status;
    logic [OUT_IDX_W-1:0]  slot;
    logic [OUT_IDX_W-1:0]  home;
  } ins_result_t;

  // One row of the directed table; want is used only where given is set.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [TAG_W-1:0] tag;
    bit               given;
    ins_result_t      want;
  } ins_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [ID_W-1:0]      emp_id = '0;
  logic [TAG_W-1:0]     name_tag = '0;
  logic                 busy;
  logic                 done;
  logic                 status;
  logic [OUT_IDX_W-1:0] slot;
  logic [OUT_IDX_W-1:0] home_slot;

  // Local copy of the table: occupancy plus the stored record fields.
  bit               slot_taken [SLOTS];
  logic [ID_W-1:0]  held_id    [SLOTS];
  logic [TAG_W-1:0] held_tag   [SLOTS];
  logic [3:0]       held_home  [SLOTS];

  ins_result_t pending_results [$];
  int          err_count = 0;
  int          idle_run  = 0;

  // Directed rows. The table fills up in rows 0 to 15:
  //   id 0 and the largest id land straight in their home slots (0 and 15),
  //   id 16 collides at slot 0, id 31 collides at 15 and wraps round to 2,
  //   the repeated id 0 is stored again (duplicates are not detected),
  //   alternating bit patterns land at 5 and 10, and nine ids with home
  //   slot 4 walk along every remaining gap, skipping the taken slots.
  // Rows 16 to 19 hit the full table: status full, slot 0, home still reported.
  ins_row_t dir_rows [NUM_DIR] = '{
    '{31'h0000_0000, 32'h0000_0000, 1'b1, '{RES_STORED, 4'd0,  4'd0}},
    '{31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{RES_STORED, 4'd15, 4'd15}},
    '{31'h0000_0010, 32'h1234_5678, 1'b0, '0},
    '{31'h0000_001F, 32'h8765_4321, 1'b0, '0},
    '{31'h0000_0000, 32'hDEAD_BEEF, 1'b0, '0},
    '{31'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
    '{31'h2AAA_AAAA, 32'h5555_5555, 1'b0, '0},
    '{31'h0000_0004, 32'h0000_0001, 1'b0, '0},
    '{31'h0000_0014, 32'h8000_0000, 1'b0, '0},
    '{31'h4000_0004, 32'h0F0F_0F0F, 1'b0, '0},
    '{31'h7FFF_FFF4, 32'hF0F0_F0F0, 1'b0, '0},
    '{31'h0000_0024, 32'h0000_FFFF, 1'b0, '0},
    '{31'h0000_0034, 32'hFFFF_0000, 1'b0, '0},
    '{31'h0000_0044, 32'h3C3C_3C3C, 1'b0, '0},
    '{31'h0000_0054, 32'hC3C3_C3C3, 1'b0, '0},
    '{31'h0000_0064, 32'h7FFF_FFFF, 1'b0, '0},
    '{31'h0000_0007, 32'h0000_0000, 1'b1, '{RES_FULL,   4'd0,  4'd7}},
    '{31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{RES_FULL,   4'd0,  4'd15}},
    '{31'h0000_0000, 32'h0000_0000, 1'b1, '{RES_FULL,   4'd0,  4'd0}},
    '{31'h0000_000C, 32'h5A5A_5A5A, 1'b0, '0}
  };

  linear_probe_hash_insert_core #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .emp_id   (emp_id),
    .name_tag (name_tag),
    .done     (done),
    .status   (status),
    .slot     (slot),
    .home_slot(home_slot)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Probe from the home slot, wrapping, to the first free slot; claim it and
  // record the entry. With no free slot, leave the table alone and say full.
  function automatic ins_result_t predict_insert(input logic [ID_W-1:0] id,
                                                 input logic [TAG_W-1:0] tag);
    int          home;
    int          probe;
    bit          hit;
    ins_result_t r;
    home  = int'(id % SLOTS);
    probe = home;
    hit   = 1'b0;
    for (int n = 0; n < SLOTS && !hit; n++) begin
      if (!slot_taken[probe]) hit = 1'b1;
      else probe = (probe + 1) % SLOTS;
    end
    r.home = home[OUT_IDX_W-1:0];
    if (hit) begin
      slot_taken[probe] = 1'b1;
      held_id[probe]    = id;
      held_tag[probe]   = tag;
      held_home[probe]  = home[3:0];
      r.status          = RES_STORED;
      r.slot            = probe[OUT_IDX_W-1:0];
    end else begin
      r.status = RES_FULL;
      r.slot   = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    err_count++;
  endtask

  // Idle for a random burst now and then, except in quiet stretches and in
  // the calm tail of the run.
  function automatic int pick_gap(input bit quiet);
    if (quiet || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, 13);
  endfunction

  // Present one item at the falling edge, hold it until the core takes it,
  // then log the outcome. Keep start high across back-to-back items; drop it
  // only for an idle burst.
  task automatic drive_item(input logic [ID_W-1:0] id, input logic [TAG_W-1:0] tag,
                            input int gap, input bit given, input ins_result_t want);
    ins_result_t r;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start    <= 1'b1;
    emp_id   <= id;
    name_tag <= tag;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Advance the local table on every item, even where the row gives the answer.
    r = predict_insert(id, tag);
    pending_results.push_back(given ? want : r);
  endtask

  // Result checker: each done pulse must match the oldest logged outcome.
  always @(posedge clk) begin
    ins_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with no insert outstanding", $time);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (slot !== want.slot) report_mismatch("slot", slot, want.slot);
        if (home_slot !== want.home) report_mismatch("home_slot", home_slot, want.home);
      end
    end
  end

  // Watchdog: restart the count whenever an item is taken or a result shows.
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= STALL_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [ID_W-1:0]  id;
    logic [TAG_W-1:0] tag;
    bit               quiet;

    foreach (slot_taken[k]) slot_taken[k] = 1'b0;

    // Hold reset, then release it at a falling edge; the core then clears its table by itself.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table.
    for (int i = 0; i < NUM_DIR; i++) begin
      drive_item(dir_rows[i].id, dir_rows[i].tag, pick_gap(1'b0),
                 dir_rows[i].given, dir_rows[i].want);
    end

    // Random inserts. The table is full by now, so these press on the
    // exhaustive probe with every id width and home slot.
    quiet = 1'b0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0:       id = '0;
        1:       id = '1;
        2:       id = ID_W'($urandom_range(0, 63));
        default: id = ID_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0:       tag = '0;
        1:       tag = '1;
        default: tag = $urandom;
      endcase
      drive_item(id, tag, pick_gap(quiet || i >= RAND_ITEMS - CALM_TAIL), 1'b0, '0);
    end

    @(negedge clk);
    start <= 1'b0;

    // Drain outstanding results, then keep the clock running to catch anything stray.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 14) @(posedge clk);

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
